// ===== hdl/frp_pkg.sv =====
// Shared types and constants for the frame rate pacer.
`default_nettype none
package frp_pkg;
   localparam int TIME_WIDTH     = 64;
   localparam int RATE_W         = 16;
   localparam int RATE_FRAC_BITS = 8;
   localparam int RATE_INT_BITS  = RATE_W - RATE_FRAC_BITS;
   localparam int NUM_W          = 64;
   localparam int ALU_W          = ((NUM_W > TIME_WIDTH) ? NUM_W : TIME_WIDTH) + 2;
   localparam int RSP_W          = 216;

   localparam logic [7:0]  DEFAULT_RATE    = 8'd30;
   localparam logic [7:0]  MAX_RATE        = 8'd240;
   localparam logic [31:0] RESET_TICK_RATE = 32'd1000000;
   localparam logic [31:0] RESET_PERIOD    = RESET_TICK_RATE / 32'd30;
   localparam logic [3:0]  RESET_SLACK     = 4'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TARGET_RATE  = 2'd0;
   localparam logic [1:0] CSR_TICK_RATE    = 2'd1;
   localparam logic [1:0] CSR_RESYNC_SLACK = 2'd2;

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [ALU_W-1:0]      alu_word_type;
endpackage
`default_nettype wire

// ===== hdl/frame_rate_pacer.sv =====
// Top level of the frame rate pacer: sequencer, state and stream ports.
// A start item passes through 32 restoring steps of the shared subtractor for the period
// division, the deadline add and the result register; on a frame item the 16-step rate
// division of a closing window is the long part.
// Throughput: one item at a time; the next is taken the cycle after the result registers.
// Reset: synchronous; registers return to 30 fps, 1000000 ticks/s, slack 2, counters clear.
`default_nettype none
module frame_rate_pacer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // now_ticks
   input  logic                      req_tuser,   // req_type
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // must_wait, wait_until, late, resynced, measured_rate, rate_updated,
   // late_total, frame_total, step_ticks, zero fill
   output logic [frp_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import frp_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DIV      = 4'd1;
   localparam logic [3:0] ST_DEADLINE = 4'd2;
   localparam logic [3:0] ST_DIFF     = 4'd3;
   localparam logic [3:0] ST_SLACK    = 4'd4;
   localparam logic [3:0] ST_ADVANCE  = 4'd5;
   localparam logic [3:0] ST_ELAPSED  = 4'd6;
   localparam logic [3:0] ST_WINDOW   = 4'd7;
   localparam logic [3:0] ST_MUL      = 4'd8;
   localparam logic [3:0] ST_SAT      = 4'd9;
   localparam logic [3:0] ST_DONE     = 4'd10;

   localparam logic MODE_PERIOD = 1'b0;
   localparam logic MODE_RATE   = 1'b1;

   logic [3:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        mode_ff, mode_in;
   time_type    now_ff, now_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   time_type    elap_ff, elap_in;
   logic [NUM_W-1:0] num_ff, num_in;

   time_type    deadline_ff, deadline_in;
   time_type    wb_ff, wb_in;
   logic [31:0] wc_ff, wc_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [31:0] latec_ff, latec_in;
   logic [63:0] framec_ff, framec_in;
   logic [31:0] period_ff, period_in;

   logic        mw_ff, mw_in;
   time_type    wu_ff, wu_in;
   logic        late_ff, late_in;
   logic        rs_ff, rs_in;
   logic        upd_ff, upd_in;

   logic [7:0]  tgt_ff, tgt_in;
   logic [31:0] tick_ff, tick_in;
   logic [3:0]  slack_ff, slack_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   alu_word_type alu_a, alu_b, alu_res;
   logic         alu_sub, alu_neg;

   logic [7:0]  tgt_eff;
   logic [35:0] slack_prod;
   logic [63:0] elap_ext;
   logic        elap_top;
   logic [NUM_W+RATE_W-1:0] num_sh;
   logic        div_bit;

   frp_alu u_alu (
      .a_opd  (alu_a),
      .b_opd  (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .neg    (alu_neg)
   );

   assign tgt_eff    = (tgt_ff == 8'd0 || tgt_ff > MAX_RATE) ? DEFAULT_RATE : tgt_ff;
   assign slack_prod = slack_ff * period_ff;
   assign elap_ext   = 64'(elap_ff);
   // Saturation compares num against elapsed scaled up by the integer bits of the rate.
   assign elap_top   = (elap_ext >> (64 - RATE_INT_BITS)) != 64'd0;
   assign num_sh     = (NUM_W+RATE_W)'(num_ff) << RATE_FRAC_BITS;
   assign div_bit    = q_ff[31];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         ST_DIV: begin
            alu_a = ALU_W'({rem_ff, div_bit});
            alu_b = (mode_ff == MODE_PERIOD) ? ALU_W'(tgt_eff) : ALU_W'(elap_ff);
         end
         ST_DEADLINE: begin
            alu_a   = ALU_W'(now_ff);
            alu_b   = ALU_W'(period_ff);
            alu_sub = 1'b0;
         end
         ST_DIFF: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(deadline_ff);
         end
         ST_SLACK: begin
            alu_a = ALU_W'(slack_prod);
            alu_b = ALU_W'(rem_ff);
         end
         ST_ADVANCE: begin
            alu_a   = ALU_W'(deadline_ff);
            alu_b   = ALU_W'(period_ff);
            alu_sub = 1'b0;
         end
         ST_ELAPSED: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(wb_ff);
         end
         ST_WINDOW: begin
            alu_a = ALU_W'(elap_ff);
            alu_b = ALU_W'(tick_ff);
         end
         ST_SAT: begin
            alu_a = ALU_W'(num_ff);
            alu_b = ALU_W'(elap_ext << RATE_INT_BITS);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      elap_in      = elap_ff;
      num_in       = num_ff;
      deadline_in  = deadline_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      rate_in      = rate_ff;
      latec_in     = latec_ff;
      framec_in    = framec_ff;
      period_in    = period_ff;
      mw_in        = mw_ff;
      wu_in        = wu_ff;
      late_in      = late_ff;
      rs_in        = rs_ff;
      upd_in       = upd_ff;
      tgt_in       = tgt_ff;
      tick_in      = tick_ff;
      slack_in     = slack_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_RATE:  tgt_in   = csr_data[7:0];
            CSR_TICK_RATE:    tick_in  = csr_data;
            CSR_RESYNC_SLACK: slack_in = csr_data[3:0];
            default:          tgt_in   = tgt_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in  = req_tdata[TIME_WIDTH-1:0];
               mw_in   = 1'b0;
               wu_in   = '0;
               late_in = 1'b0;
               rs_in   = 1'b0;
               upd_in  = 1'b0;
               if (req_tuser == REQ_START) begin
                  rem_in   = '0;
                  q_in     = tick_ff;
                  cnt_in   = 5'd31;
                  mode_in  = MODE_PERIOD;
                  state_in = ST_DIV;
               end else begin
                  framec_in = framec_ff + 64'd1;
                  wc_in     = wc_ff + 32'd1;
                  state_in  = ST_DIFF;
               end
            end
         end
         ST_DIV: begin
            // One restoring division step: the dividend bit leaves the top of q_ff
            // while the quotient bit enters at the bottom.
            if (!alu_neg) begin
               rem_in = alu_res[63:0];
            end else begin
               rem_in = {rem_ff[62:0], div_bit};
            end
            q_in   = {q_ff[30:0], !alu_neg};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (mode_ff == MODE_PERIOD) begin
                  period_in = {q_ff[30:0], !alu_neg};
                  state_in  = ST_DEADLINE;
               end else begin
                  rate_in  = q_in[RATE_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_DEADLINE: begin
            deadline_in = alu_res[TIME_WIDTH-1:0];
            wu_in       = alu_res[TIME_WIDTH-1:0];
            wb_in       = now_ff;
            wc_in       = '0;
            rate_in     = '0;
            latec_in    = '0;
            framec_in   = '0;
            state_in    = ST_DONE;
         end
         ST_DIFF: begin
            rem_in = 64'(alu_res[TIME_WIDTH-1:0]);
            if (!alu_neg && alu_res[TIME_WIDTH-1:0] != '0) begin
               late_in  = 1'b1;
               latec_in = latec_ff + 32'd1;
               state_in = ST_SLACK;
            end else begin
               mw_in    = 1'b1;
               wu_in    = deadline_ff;
               state_in = ST_ADVANCE;
            end
         end
         ST_SLACK: begin
            // Behind by more than the tolerated slack: restart the schedule from now.
            if (alu_neg) begin
               rs_in       = 1'b1;
               deadline_in = now_ff;
            end
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            deadline_in = alu_res[TIME_WIDTH-1:0];
            state_in    = ST_ELAPSED;
         end
         ST_ELAPSED: begin
            elap_in  = alu_res[TIME_WIDTH-1:0];
            state_in = alu_neg ? ST_DONE : ST_WINDOW;
         end
         ST_WINDOW: begin
            state_in = alu_neg ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            num_in   = wc_ff * tick_ff;
            wc_in    = '0;
            wb_in    = now_ff;
            upd_in   = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (num_ff == '0) begin
               rate_in  = '0;
               state_in = ST_DONE;
            end else if (!elap_top && !alu_neg) begin
               rate_in  = '1;
               state_in = ST_DONE;
            end else begin
               rem_in   = 64'(num_ff >> RATE_INT_BITS);
               q_in     = {num_sh[RATE_W-1:0], 16'd0};
               cnt_in   = 5'(RATE_W - 1);
               mode_in  = MODE_RATE;
               state_in = ST_DIV;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, period_ff, framec_ff, latec_ff, upd_ff, rate_ff,
                               rs_ff, late_ff, 64'(wu_ff), mw_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= MODE_PERIOD;
         deadline_ff  <= '0;
         wb_ff        <= '0;
         wc_ff        <= '0;
         rate_ff      <= '0;
         latec_ff     <= '0;
         framec_ff    <= '0;
         period_ff    <= RESET_PERIOD;
         tgt_ff       <= DEFAULT_RATE;
         tick_ff      <= RESET_TICK_RATE;
         slack_ff     <= RESET_SLACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         deadline_ff  <= deadline_in;
         wb_ff        <= wb_in;
         wc_ff        <= wc_in;
         rate_ff      <= rate_in;
         latec_ff     <= latec_in;
         framec_ff    <= framec_in;
         period_ff    <= period_in;
         tgt_ff       <= tgt_in;
         tick_ff      <= tick_in;
         slack_ff     <= slack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      elap_ff     <= elap_in;
      num_ff      <= num_in;
      mw_ff       <= mw_in;
      wu_ff       <= wu_in;
      late_ff     <= late_in;
      rs_ff       <= rs_in;
      upd_ff      <= upd_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

// ===== hdl/frp_alu.sv =====
// Shared add/subtract unit used by the pacer sequencer.
`default_nettype none
module frp_alu (
   input  frp_pkg::alu_word_type a_opd,
   input  frp_pkg::alu_word_type b_opd,
   input  logic                  sub,
   output frp_pkg::alu_word_type result,
   output logic                  neg
);
   import frp_pkg::*;

   assign result = sub ? (a_opd - b_opd) : (a_opd + b_opd);
   // Operands are zero-extended by two bits, so the top bit flags a < b.
   assign neg = result[ALU_W-1];
endmodule
`default_nettype wire
